FILE: sv/trsc_pkg.sv
// Shared types, constants and table for the three-rotor shift cipher.
package trsc_pkg;

  localparam int unsigned ALPHA_SIZE = 27;
  localparam int unsigned ROTOR_SPAN = 10;
  localparam logic [7:0] SPACE_CODE = 8'd32;
  localparam logic [7:0] CODE_A = 8'd65;
  localparam logic [7:0] CODE_Z = 8'd90;
  localparam logic [4:0] SPACE_IDX = 5'd26;
  localparam logic [3:0] POS_MAX = 4'd9;

  typedef logic [3:0] pos_t;
  typedef logic [4:0] sym_t;
  typedef logic [4:0] key_t;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_START_FIRST = 2'd1,
    REG_START_SECOND = 2'd2,
    REG_START_THIRD = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] char_in;
    sym_t idx;
    logic in_alpha;
    key_t key;
  } stage_t;

  function automatic logic [3:0] rotor_value(input pos_t pos);
    logic [3:0] v;
    case (pos)
      4'd0: v = 4'd7;
      4'd1: v = 4'd3;
      4'd2: v = 4'd0;
      4'd3: v = 4'd1;
      4'd4: v = 4'd9;
      4'd5: v = 4'd5;
      4'd6: v = 4'd2;
      4'd7: v = 4'd6;
      4'd8: v = 4'd4;
      default: v = 4'd8;
    endcase
    return v;
  endfunction

  function automatic pos_t clamp_pos(input pos_t v);
    return (v > POS_MAX) ? POS_MAX : v;
  endfunction

endpackage

FILE: sv/trsc_rotor.sv
// Rotor odometer: holds the three positions, forms the running key, steps per item.
module trsc_rotor import trsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic restart,
  input  pos_t start_first,
  input  pos_t start_second,
  input  pos_t start_third,
  output key_t key
);

  pos_t pos_first_r, pos_second_r, pos_third_r;
  pos_t pos_first_nxt, pos_second_nxt, pos_third_nxt;
  pos_t eff_first, eff_second, eff_third;
  logic carry_first, carry_second;

  always_comb begin
    eff_first = restart ? clamp_pos(start_first) : pos_first_r;
    eff_second = restart ? clamp_pos(start_second) : pos_second_r;
    eff_third = restart ? clamp_pos(start_third) : pos_third_r;
    key = 5'(rotor_value(eff_first)) + 5'(rotor_value(eff_second))
        + 5'(rotor_value(eff_third));
    carry_first = (eff_first >= POS_MAX);
    carry_second = carry_first && (eff_second >= POS_MAX);
    pos_first_nxt = carry_first ? 4'd0 : eff_first + 4'd1;
    pos_second_nxt = eff_second;
    if (carry_first) begin
      pos_second_nxt = (eff_second >= POS_MAX) ? 4'd0 : eff_second + 4'd1;
    end
    pos_third_nxt = eff_third;
    if (carry_second) begin
      pos_third_nxt = (eff_third >= POS_MAX) ? 4'd0 : eff_third + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_first_r <= '0;
      pos_second_r <= '0;
      pos_third_r <= '0;
    end else if (step) begin
      pos_first_r <= pos_first_nxt;
      pos_second_r <= pos_second_nxt;
      pos_third_r <= pos_third_nxt;
    end
  end

endmodule

FILE: sv/trsc_shift.sv
// Modulo-27 shift of one staged symbol and mapping back to a character code.
module trsc_shift import trsc_pkg::*; (
  input  stage_t     stage,
  input  logic       direction,
  output logic [7:0] char_out,
  output logic       in_alpha
);

  logic [5:0] sum;
  logic [5:0] res;

  always_comb begin
    if (direction) begin
      sum = 6'(stage.idx) + 6'(ALPHA_SIZE) - 6'(stage.key);
    end else begin
      sum = 6'(stage.idx) + 6'(stage.key);
    end
    res = (sum >= 6'(ALPHA_SIZE)) ? sum - 6'(ALPHA_SIZE) : sum;
    in_alpha = stage.in_alpha;
    if (!stage.in_alpha) begin
      char_out = stage.char_in;
    end else if (res[4:0] == SPACE_IDX) begin
      char_out = SPACE_CODE;
    end else begin
      char_out = CODE_A + 8'(res);
    end
  end

endmodule

FILE: sv/three_rotor_shift_cipher.sv
// Top level: config registers, input stage, rotor key, shift and output register.
// Path: an accepted item is registered in the input stage, then shifted and registered
// in the output register, which raises out_valid; a stalled output can hold it back.
// Throughput: one item per cycle; in_ready stays high unless both stages hold
// items and the output is stalled.
// Reset (rst_n low, synchronous): rotors, config registers and valid flags clear.
module three_rotor_shift_cipher import trsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_out,
  output logic        out_in_alphabet,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic direction_r;
  pos_t start_first_r, start_second_r, start_third_r;
  reg_idx_t reg_sel;
  logic cfg_write;

  stage_t stage_r, stage_nxt;
  logic stage_valid_r;
  logic out_valid_r;
  logic [7:0] out_char_r;
  logic out_alpha_r;
  logic [7:0] shift_char;
  logic shift_alpha;
  logic in_accept, stage_adv;
  key_t key;
  sym_t idx;
  logic in_alpha;

  assign pready = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      start_first_r <= '0;
      start_second_r <= '0;
      start_third_r <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_DIRECTION:    direction_r <= pwdata[0];
        REG_START_FIRST:  start_first_r <= pwdata[3:0];
        REG_START_SECOND: start_second_r <= pwdata[3:0];
        REG_START_THIRD:  start_third_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DIRECTION:    prdata = {31'd0, direction_r};
      REG_START_FIRST:  prdata = {28'd0, start_first_r};
      REG_START_SECOND: prdata = {28'd0, start_second_r};
      REG_START_THIRD:  prdata = {28'd0, start_third_r};
      default:          prdata = '0;
    endcase
  end

  assign stage_adv = !out_valid_r || out_ready;
  assign in_ready = !stage_valid_r || stage_adv;
  assign in_accept = in_valid && in_ready;

  trsc_rotor u_rotor (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_accept),
    .restart      (in_restart),
    .start_first  (start_first_r),
    .start_second (start_second_r),
    .start_third  (start_third_r),
    .key          (key)
  );

  always_comb begin
    in_alpha = 1'b1;
    if (in_char_in >= CODE_A && in_char_in <= CODE_Z) begin
      idx = 5'(in_char_in - CODE_A);
    end else if (in_char_in == SPACE_CODE) begin
      idx = SPACE_IDX;
    end else begin
      idx = '0;
      in_alpha = 1'b0;
    end
    stage_nxt.char_in = in_char_in;
    stage_nxt.idx = idx;
    stage_nxt.in_alpha = in_alpha;
    stage_nxt.key = key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_r <= stage_nxt;
    end
  end

  trsc_shift u_shift (
    .stage     (stage_r),
    .direction (direction_r),
    .char_out  (shift_char),
    .in_alpha  (shift_alpha)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_adv) begin
      out_valid_r <= stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage_valid_r) begin
      out_char_r <= shift_char;
      out_alpha_r <= shift_alpha;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_in_alphabet = out_alpha_r;

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("item accepted while both stages are stalled");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (key <= 5'd27))
    else $error("running key out of range");

  a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_alpha_r) |->
      ((out_char_r >= CODE_A && out_char_r <= CODE_Z) || out_char_r == SPACE_CODE))
    else $error("in-alphabet item carries a code outside the alphabet");

endmodule
